@@ hw/rtl/rwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwm_pkg: shared types and constants of the windowed chunk mapper
// Sizes, status codes and the idle-queue cell control word.
// ----------------------------------------------------------------------------
`default_nettype none
package rwm_pkg;
  localparam int unsigned PhysChunks = 1024;
  localparam int unsigned Slots      = 64;
  localparam int unsigned ChunkW     = $clog2(PhysChunks);
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned CountW     = $clog2(Slots + 1);
  localparam int unsigned RefW       = 16;
  localparam logic [RefW-1:0] RefMax = '1;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_NO_MEMORY       = 3'd1,
    ST_WOULD_BLOCK     = 3'd2,
    ST_BAD_ADDRESS     = 3'd3,
    ST_NOT_CHECKED_OUT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_WINDOW_BASE = 2'd0,
    CFG_CHUNK_SHIFT = 2'd1,
    CFG_SLOT_COUNT  = 2'd2
  } cfg_idx_e;

  // Command broadcast to every idle-queue cell.
  typedef struct packed {
    logic              push;    // append at tail position
    logic              remove;  // drop entry matching key, shift rest down
    logic [ChunkW-1:0] key;
    logic [CountW-1:0] count;   // current fill
  } idle_cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/rwm_if.sv @@
// ----------------------------------------------------------------------------
// rwm_req_if / rwm_rsp_if / rwm_cfg_if: valid-ready channels of the mapper
// Each carries valid, ready and the payload fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface rwm_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [39:0] phys_address;
  logic [47:0] virt_address;
  logic        dont_wait;
  modport source (output valid, operation, phys_address, virt_address, dont_wait,
                  input ready);
  modport sink   (input valid, operation, phys_address, virt_address, dont_wait,
                  output ready);
endinterface

interface rwm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] mapped_address;
  logic        install_mapping;
  logic [47:0] install_virt;
  logic [39:0] install_phys;
  logic        wake_waiter;
  modport source (output valid, status, mapped_address, install_mapping,
                  install_virt, install_phys, wake_waiter, input ready);
  modport sink   (input valid, status, mapped_address, install_mapping,
                  install_virt, install_phys, wake_waiter, output ready);
endinterface

interface rwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rwm_idle_cell.sv @@
// ----------------------------------------------------------------------------
// rwm_idle_cell: one position of the idle LRU queue
// Holds one chunk index; shifts its upper neighbor in on a removal at or below it.
// ----------------------------------------------------------------------------
`default_nettype none
module rwm_idle_cell (
  input  wire logic                       clk_i,
  input  wire rwm_pkg::idle_cmd_t         cmd_i,
  input  wire logic [rwm_pkg::CountW-1:0] pos_i,
  input  wire logic                       hit_below_i,  // match at a lower position
  input  wire logic [rwm_pkg::ChunkW-1:0] upper_i,      // neighbor above
  output logic                            hit_o,        // match here or below
  output logic [rwm_pkg::ChunkW-1:0]      entry_o
);
  logic [rwm_pkg::ChunkW-1:0] entry_q, entry_d;
  logic live, hit_here;

  assign live     = pos_i < cmd_i.count;
  assign hit_here = live && (entry_q == cmd_i.key);
  assign hit_o    = hit_below_i || hit_here;
  assign entry_o  = entry_q;

  // Shift down over the removed entry, or take the pushed chunk at the tail.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.remove && hit_o && live) begin
      entry_d = upper_i;
    end else if (cmd_i.push && pos_i == cmd_i.count) begin
      entry_d = cmd_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/rwm_idle_queue.sv @@
// ----------------------------------------------------------------------------
// rwm_idle_queue: chain of idle cells forming the LRU queue of idle chunks
// Head is position zero; the hit chain runs from head to tail.
// ----------------------------------------------------------------------------
`default_nettype none
module rwm_idle_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rwm_pkg::idle_cmd_t         cmd_i,
  output logic [rwm_pkg::CountW-1:0]      count_o,
  output logic [rwm_pkg::ChunkW-1:0]      head_o
);
  localparam int unsigned N = rwm_pkg::Slots;
  logic [rwm_pkg::ChunkW-1:0] entry [N];
  logic [N:0] hit;
  logic [rwm_pkg::CountW-1:0] count_q, count_d;
  rwm_pkg::idle_cmd_t cmd;

  always_comb begin
    cmd = cmd_i;
    cmd.count = count_q;
  end

  assign hit[0] = 1'b0;
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [rwm_pkg::ChunkW-1:0] upper;
    if (g == N - 1) begin : g_top
      assign upper = entry[g];
    end else begin : g_mid
      assign upper = entry[g+1];
    end
    rwm_idle_cell u_cell (
      .clk_i,
      .cmd_i      (cmd),
      .pos_i      (rwm_pkg::CountW'(g)),
      .hit_below_i(hit[g]),
      .upper_i    (upper),
      .hit_o      (hit[g+1]),
      .entry_o    (entry[g])
    );
  end

  // Track fill: removal only when a match exists, push only when room.
  always_comb begin
    count_d = count_q;
    if (cmd_i.remove && hit[N]) begin
      count_d = count_q - 1'b1;
    end else if (cmd_i.push && count_q < rwm_pkg::CountW'(N)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign head_o  = entry[0];

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rwm_pkg::CountW'(N)) else $error("idle count overflow");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.remove)) else $error("push and remove together");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && count_q < rwm_pkg::CountW'(N) |=> count_q == $past(count_q) + 1'b1)
    else $error("push lost");
endmodule
`default_nettype wire

@@ hw/rtl/refcounted_window_mapper_lru_unit.sv @@
// ----------------------------------------------------------------------------
// refcounted_window_mapper_lru_unit: windowed chunk mapper with LRU reuse
// Maps physical chunks into window slots with reference counts.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (get or put), one response per request leaves
// on rsp; registers are written on cfg while the block is idle.
// After the accepting edge the block steps through its states in order:
// read the chunk and slot tables (registered memory read), read the owner or
// victim chunk entry, decide and write back, present the response. One
// request is in flight at a time and req is ready again only in the cycle
// after the response is taken, so no new request is accepted before the last
// one is through, as the memory read-modify-write sequence requires.
// The idle LRU queue is a chain of 64 cells updated in the decide cycle.
// After reset a clearing pass sweeps the chunk tables (mapped flag and
// reference count), during which req is not ready.
// When the receiver stalls, the response is held in its register and no new
// request is accepted until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module refcounted_window_mapper_lru_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwm_req_if.sink   req,
  rwm_rsp_if.source rsp,
  rwm_cfg_if.sink   cfg
);
  localparam int unsigned CW = rwm_pkg::ChunkW;
  localparam int unsigned SW = rwm_pkg::SlotW;
  localparam int unsigned RW = rwm_pkg::RefW;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RDC   = 6'b000100,
    S_RDS   = 6'b001000,
    S_EXEC  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [47:0] base_q;
  logic [4:0]  shift_q;
  logic [6:0]  scount_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      shift_q  <= 5'd12;
      scount_q <= 7'd64;
    end else if (cfg.valid) begin
      case (cfg.index)
        rwm_pkg::CFG_WINDOW_BASE: base_q   <= cfg.data;
        rwm_pkg::CFG_CHUNK_SHIFT: shift_q  <= cfg.data[4:0];
        rwm_pkg::CFG_SLOT_COUNT:  scount_q <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // Latched request.
  logic        op_q, dw_q;
  logic [39:0] pa_q;
  logic [47:0] va_q;
  assign req.ready = (state_q == S_IDLE);
  wire acc = req.valid && req.ready;
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q <= req.operation;
      pa_q <= req.phys_address;
      va_q <= req.virt_address;
      dw_q <= req.dont_wait;
    end
  end

  // Address decode (from latched request).
  logic [63:0] offmask, span, rel;
  logic [39:0] idx40;
  logic        get_bad, put_out;
  logic [47:0] slot64w;
  logic [rwm_pkg::CountW-1:0] live_n;
  always_comb begin
    live_n  = (scount_q > 7'(rwm_pkg::Slots)) ? rwm_pkg::CountW'(rwm_pkg::Slots)
                                                : rwm_pkg::CountW'(scount_q);
    offmask = (64'd1 << shift_q) - 64'd1;
    idx40   = pa_q >> shift_q;
    get_bad = idx40 >= 40'(rwm_pkg::PhysChunks);
    span    = 64'(live_n) << shift_q;
    rel     = 64'(va_q) - 64'(base_q);
    put_out = (va_q < base_q) || (rel >= span);
    slot64w = rel[47:0] >> shift_q;
  end
  wire [CW-1:0] idx = idx40[CW-1:0];
  wire [SW-1:0] pslot = slot64w[SW-1:0];
  wire pslot_big = slot64w >= 48'(rwm_pkg::Slots);

  // Chunk tables: mapped + refs (cleared), slot (undefined until written).
  logic [RW:0]   cref_mem [rwm_pkg::PhysChunks];
  logic [SW-1:0] cslot_mem [rwm_pkg::PhysChunks];
  logic [RW:0]   cref_rd;
  logic [SW-1:0] cslot_rd;
  logic          cw_en, cw_slot_en;
  logic [CW-1:0] cw_addr, cr_addr;
  logic [RW:0]   cw_data;
  logic [SW-1:0] cw_slot;
  logic [CW:0]   clr_q;

  // Slot tables.
  logic [CW-1:0] owner_mem [rwm_pkg::Slots];
  logic [rwm_pkg::Slots-1:0] sused_q;
  logic [CW-1:0] owner_rd;
  logic          ow_en;
  logic [SW-1:0] ow_addr, or_addr;
  logic [CW-1:0] ow_data;

  // The chunk read in S_RDS (victim or owner) reuses the read port.
  logic [RW:0]   ref_a_q;      // get chunk entry
  logic [SW-1:0] slot_a_q;
  logic [RW:0]   ref_b;        // victim or put owner entry (read in RDS)
  logic [SW-1:0] slot_b;

  logic [rwm_pkg::CountW-1:0] idle_cnt;
  logic [CW-1:0] idle_head;
  rwm_pkg::idle_cmd_t icmd;

  // Victim is unmapped at eviction: clear its mapped flag, keep its count.
  // Done in the cycle after exec through a pending write.
  logic          evict_q;
  logic [CW-1:0] evict_chunk_q;
  logic [RW:0]   evict_ref_q;
  logic          ev_we;
  assign ev_we = evict_q;

  always_comb begin
    cr_addr = idx;
    if (state_q == S_RDS) cr_addr = op_q ? owner_rd : idle_head;
    or_addr = pslot;
  end

  always_ff @(posedge clk_i) begin
    cref_rd  <= cref_mem[cr_addr];
    cslot_rd <= cslot_mem[cr_addr];
    owner_rd <= owner_mem[or_addr];
    if (cw_en) cref_mem[cw_addr] <= cw_data;
    else if (ev_we) cref_mem[evict_chunk_q] <= evict_ref_q;
    if (cw_slot_en) cslot_mem[cw_addr] <= cw_slot;
    if (ow_en) owner_mem[ow_addr] <= ow_data;
    if (state_q == S_RDS) begin
      ref_a_q  <= cref_rd;
      slot_a_q <= cslot_rd;
    end
  end
  assign ref_b  = cref_rd;
  assign slot_b = cslot_rd;

  rwm_idle_queue u_idle (
    .clk_i, .rst_ni, .cmd_i(icmd), .count_o(idle_cnt), .head_o(idle_head)
  );

  logic [rwm_pkg::CountW-1:0] nu_q, nu_d;
  logic [RW-1:0] wait_q, wait_d;
  logic [rwm_pkg::Slots-1:0] sused_d;
  logic [2:0]  st_d, st_q;
  logic [47:0] ma_d, ma_q, iv_d, iv_q;
  logic [39:0] ip_d, ip_q;
  logic        im_d, im_q, ww_d, ww_q;
  logic [SW-1:0] nslot;
  logic [47:0] sbase;
  logic [63:0] pchunk;
  logic [RW-1:0] rnew;

  // Decide and write back in S_EXEC; the owner's chunk entry for put is read in S_RDS.
  always_comb begin
    state_d = state_q;
    cw_en = 1'b0; cw_slot_en = 1'b0; cw_addr = idx; cw_data = '0; cw_slot = '0;
    ow_en = 1'b0; ow_addr = '0; ow_data = idx;
    icmd = '0;
    nu_d = nu_q; wait_d = wait_q; sused_d = sused_q;
    st_d = st_q; ma_d = ma_q; iv_d = iv_q; ip_d = ip_q; im_d = im_q; ww_d = ww_q;
    nslot = '0; sbase = '0; pchunk = '0; rnew = '0;
    case (state_q)
      S_CLEAR: begin
        cw_en = 1'b1; cw_addr = clr_q[CW-1:0];
        if (clr_q == (CW+1)'(rwm_pkg::PhysChunks - 1)) state_d = S_IDLE;
      end
      S_IDLE:  if (acc) state_d = S_RDC;
      S_RDC:   state_d = S_RDS;
      S_RDS:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_RESP;
        st_d = rwm_pkg::ST_OK; ma_d = '0; iv_d = '0; ip_d = '0; im_d = 1'b0; ww_d = 1'b0;
        if (!op_q) begin
          if (get_bad) begin
            st_d = rwm_pkg::ST_BAD_ADDRESS;
          end else if (ref_a_q[RW]) begin
            if (ref_a_q[RW-1:0] == '0) begin
              icmd.remove = 1'b1; icmd.key = idx;
            end
            rnew = (ref_a_q[RW-1:0] == rwm_pkg::RefMax) ? ref_a_q[RW-1:0]
                                                      : ref_a_q[RW-1:0] + 1'b1;
            cw_en = 1'b1; cw_addr = idx; cw_data = {1'b1, rnew};
            sbase = base_q + 48'(64'(slot_a_q) << shift_q);
            ma_d = sbase + 48'(64'(pa_q) & offmask);
          end else if (nu_q < live_n || idle_cnt != '0) begin
            if (nu_q < live_n) begin
              nslot = nu_q[SW-1:0]; nu_d = nu_q + 1'b1;
            end else begin
              nslot = slot_b;
              icmd.remove = 1'b1; icmd.key = idle_head;
            end
            // Bind: new chunk gets slot and one reference (ref starts at 0 or
            // held value when unmapped; count was left by earlier use).
            rnew = (ref_a_q[RW-1:0] == rwm_pkg::RefMax) ? ref_a_q[RW-1:0]
                                                      : ref_a_q[RW-1:0] + 1'b1;
            cw_en = 1'b1; cw_slot_en = 1'b1; cw_addr = idx;
            cw_data = {1'b1, rnew}; cw_slot = nslot;
            ow_en = 1'b1; ow_addr = nslot; ow_data = idx;
            sused_d[nslot] = 1'b1;
            sbase  = base_q + 48'(64'(nslot) << shift_q);
            pchunk = 64'(idx) << shift_q;
            ma_d = sbase + 48'(64'(pa_q) & offmask);
            im_d = 1'b1; iv_d = sbase; ip_d = pchunk[39:0];
          end else if (dw_q) begin
            st_d = rwm_pkg::ST_NO_MEMORY;
          end else begin
            st_d = rwm_pkg::ST_WOULD_BLOCK;
            if (wait_q != rwm_pkg::RefMax) wait_d = wait_q + 1'b1;
          end
        end else begin
          if (put_out) begin
            st_d = rwm_pkg::ST_BAD_ADDRESS;
          end else if (pslot_big || !sused_q[pslot]) begin
            st_d = rwm_pkg::ST_NOT_CHECKED_OUT;
          end else if (ref_b[RW-1:0] == '0) begin
            st_d = rwm_pkg::ST_NOT_CHECKED_OUT;
          end else begin
            rnew = ref_b[RW-1:0] - 1'b1;
            cw_en = 1'b1; cw_addr = owner_rd; cw_data = {ref_b[RW], rnew};
            if (rnew == '0) begin
              icmd.push = 1'b1; icmd.key = owner_rd;
              if (wait_q != '0) begin
                wait_d = wait_q - 1'b1; ww_d = 1'b1;
              end
            end
          end
        end
      end
      S_RESP:  if (rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  wire evict_now = (state_q == S_EXEC) && !op_q && !get_bad && !ref_a_q[RW]
                   && !(nu_q < live_n) && idle_cnt != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      nu_q    <= '0;
      wait_q  <= '0;
      sused_q <= '0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      nu_q    <= nu_d;
      wait_q  <= wait_d;
      sused_q <= sused_d;
      evict_q <= evict_now;
    end
  end

  always_ff @(posedge clk_i) begin
    evict_chunk_q <= idle_head;
    evict_ref_q   <= {1'b0, ref_b[RW-1:0]};
    st_q <= st_d; ma_q <= ma_d; iv_q <= iv_d; ip_q <= ip_d; im_q <= im_d; ww_q <= ww_d;
  end

  assign rsp.valid           = (state_q == S_RESP);
  assign rsp.status          = st_q;
  assign rsp.mapped_address  = ma_q;
  assign rsp.install_mapping = im_q;
  assign rsp.install_virt    = iv_q;
  assign rsp.install_phys    = ip_q;
  assign rsp.wake_waiter     = ww_q;

  a_one_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !req.ready) else $error("accept during clear");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(st_q)) else $error("rsp dropped");
  a_nu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nu_q <= rwm_pkg::CountW'(rwm_pkg::Slots)) else $error("unused slot overflow");
endmodule
`default_nettype wire

@@ dv/rwm_mapper_checker.sv @@
// ----------------------------------------------------------------------------
// rwm_mapper_checker: response predictor and comparator for the chunk mapper
// Watches the request, response and register channels, keeps its own copy of
// the chunk tables, slot tables and idle queue, and compares every response
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rwm_mapper_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwm_req_if        req,
  rwm_rsp_if        rsp,
  rwm_cfg_if        cfg,
  output int        fail_count_o,
  output int        pending_count_o
);

  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    rwm_pkg::status_e status;
    logic [47:0]      mapped_address;
    logic             install_mapping;
    logic [47:0]      install_virt;
    logic [39:0]      install_phys;
    logic             wake_waiter;
  } map_result_t;

  // Shadow registers
  logic [47:0] win_base;
  logic [4:0]  shift_amt;
  logic [6:0]  slot_limit;

  // Shadow tables
  logic                       chunk_is_mapped [rwm_pkg::PhysChunks];
  logic [rwm_pkg::SlotW-1:0]  chunk_to_slot   [rwm_pkg::PhysChunks];
  logic [rwm_pkg::RefW-1:0]   chunk_ref_cnt   [rwm_pkg::PhysChunks];
  logic [rwm_pkg::ChunkW-1:0] slot_to_chunk   [rwm_pkg::Slots];
  logic                       slot_taken      [rwm_pkg::Slots];
  int unsigned                fresh_slot;
  logic [rwm_pkg::ChunkW-1:0] lru_idle_q [$];
  logic [rwm_pkg::RefW-1:0]   blocked_cnt;

  map_result_t expected_rsp_q [$];
  int          mismatches;

  assign fail_count_o    = mismatches;
  assign pending_count_o = expected_rsp_q.size();

  // Drop the first idle entry holding this chunk
  function automatic void unlink_idle(logic [rwm_pkg::ChunkW-1:0] chunk);
    for (int i = 0; i < lru_idle_q.size(); i++) begin
      if (lru_idle_q[i] == chunk) begin
        lru_idle_q.delete(i);
        return;
      end
    end
  endfunction

  // Compute the response of one request and update the shadow state
  function automatic map_result_t map_request(logic op, logic [39:0] pa,
                                              logic [47:0] va, logic dw);
    map_result_t r;
    logic [63:0] offmask;
    logic [63:0] idx64;
    logic [63:0] span;
    logic [63:0] rel;
    logic [63:0] sbase;
    int unsigned live;
    int unsigned idx;
    int unsigned slot;
    int unsigned owner;
    int unsigned old;
    r.status          = rwm_pkg::ST_OK;
    r.mapped_address  = '0;
    r.install_mapping = 1'b0;
    r.install_virt    = '0;
    r.install_phys    = '0;
    r.wake_waiter     = 1'b0;
    offmask = (64'd1 << shift_amt) - 64'd1;
    live    = (slot_limit < rwm_pkg::Slots) ? slot_limit : rwm_pkg::Slots;
    if (op == 1'b0) begin
      idx64 = {24'd0, pa} >> shift_amt;
      if (idx64 >= rwm_pkg::PhysChunks) begin
        r.status = rwm_pkg::ST_BAD_ADDRESS;
        return r;
      end
      idx = 32'(idx64);
      // Reuse an existing mapping
      if (chunk_is_mapped[idx]) begin
        if (chunk_ref_cnt[idx] == 0) unlink_idle(rwm_pkg::ChunkW'(idx));
        if (chunk_ref_cnt[idx] != rwm_pkg::RefMax) chunk_ref_cnt[idx]++;
        slot  = chunk_to_slot[idx];
        sbase = ({16'd0, win_base} + (64'(slot) << shift_amt)) & Mask48;
        r.mapped_address = 48'(sbase + ({24'd0, pa} & offmask));
        return r;
      end
      // Take a fresh slot, else evict the oldest idle chunk
      if (fresh_slot < live) begin
        slot = fresh_slot;
        fresh_slot++;
      end else if (lru_idle_q.size() > 0) begin
        old = lru_idle_q[0];
        unlink_idle(rwm_pkg::ChunkW'(old));
        chunk_is_mapped[old] = 1'b0;
        slot = chunk_to_slot[old];
      end else begin
        if (dw) begin
          r.status = rwm_pkg::ST_NO_MEMORY;
        end else begin
          if (blocked_cnt != rwm_pkg::RefMax) blocked_cnt++;
          r.status = rwm_pkg::ST_WOULD_BLOCK;
        end
        return r;
      end
      chunk_is_mapped[idx] = 1'b1;
      chunk_to_slot[idx]   = rwm_pkg::SlotW'(slot);
      slot_to_chunk[slot]  = rwm_pkg::ChunkW'(idx);
      slot_taken[slot]     = 1'b1;
      if (chunk_ref_cnt[idx] != rwm_pkg::RefMax) chunk_ref_cnt[idx]++;
      sbase = ({16'd0, win_base} + (64'(slot) << shift_amt)) & Mask48;
      r.mapped_address  = 48'(sbase + ({24'd0, pa} & offmask));
      r.install_mapping = 1'b1;
      r.install_virt    = 48'(sbase);
      r.install_phys    = 40'((64'(idx) << shift_amt));
      return r;
    end
    // Release path
    span = 64'(live) << shift_amt;
    if (va < win_base || ({16'd0, va} - {16'd0, win_base}) >= span) begin
      r.status = rwm_pkg::ST_BAD_ADDRESS;
      return r;
    end
    rel = {16'd0, va} - {16'd0, win_base};
    if ((rel >> shift_amt) >= rwm_pkg::Slots) begin
      r.status = rwm_pkg::ST_NOT_CHECKED_OUT;
      return r;
    end
    slot = 32'(rel >> shift_amt);
    if (!slot_taken[slot]) begin
      r.status = rwm_pkg::ST_NOT_CHECKED_OUT;
      return r;
    end
    owner = slot_to_chunk[slot];
    if (chunk_ref_cnt[owner] == 0) begin
      r.status = rwm_pkg::ST_NOT_CHECKED_OUT;
      return r;
    end
    chunk_ref_cnt[owner]--;
    if (chunk_ref_cnt[owner] == 0) begin
      if (lru_idle_q.size() < rwm_pkg::Slots) lru_idle_q.push_back(rwm_pkg::ChunkW'(owner));
      if (blocked_cnt != 0) begin
        blocked_cnt--;
        r.wake_waiter = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void report_field(string name, logic [63:0] exp_v,
                                       logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Track register writes, predict on requests, compare on responses
  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t e;
    if (!rst_ni) begin
      win_base   <= '0;
      shift_amt  <= 5'd12;
      slot_limit <= 7'd64;
      for (int i = 0; i < rwm_pkg::PhysChunks; i++) begin
        chunk_is_mapped[i] = 1'b0;
        chunk_to_slot[i]   = '0;
        chunk_ref_cnt[i]   = '0;
      end
      for (int i = 0; i < rwm_pkg::Slots; i++) begin
        slot_to_chunk[i] = '0;
        slot_taken[i]    = 1'b0;
      end
      fresh_slot  = 0;
      blocked_cnt = '0;
      lru_idle_q.delete();
      expected_rsp_q.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response expected none actual status %h", $time, rsp.status);
          mismatches++;
        end else begin
          e = expected_rsp_q.pop_front();
          report_field("status", e.status, rsp.status);
          report_field("mapped_address", e.mapped_address, rsp.mapped_address);
          report_field("install_mapping", e.install_mapping, rsp.install_mapping);
          report_field("install_virt", e.install_virt, rsp.install_virt);
          report_field("install_phys", e.install_phys, rsp.install_phys);
          report_field("wake_waiter", e.wake_waiter, rsp.wake_waiter);
        end
      end
      if (req.valid && req.ready) begin
        expected_rsp_q.push_back(map_request(req.operation, req.phys_address,
                                             req.virt_address, req.dont_wait));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rwm_pkg::CFG_WINDOW_BASE: win_base   <= cfg.data;
          rwm_pkg::CFG_CHUNK_SHIFT: shift_amt  <= cfg.data[4:0];
          rwm_pkg::CFG_SLOT_COUNT:  slot_limit <= cfg.data[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus top for the windowed chunk mapper
// Runs several register settings with random get and put requests (directed
// ones also in two) under bursty sending and a stalling receiver; the checker
// beside the block predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int WatchdogLimit = 6000;
  localparam int Phases        = 6;
  localparam int ItemsPerPhase = 170;

  logic clk_i;
  logic rst_ni;

  rwm_req_if req_ch ();
  rwm_rsp_if rsp_ch ();
  rwm_cfg_if cfg_ch ();

  int fail_count;
  int pending_count;

  refcounted_window_mapper_lru_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  rwm_mapper_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .cfg             (cfg_ch),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Capture handshakes at the rising edge for the falling-edge drivers
  logic req_fire, cfg_fire;
  int   quiet_cycles = 0;
  always @(posedge clk_i) begin
    req_fire <= req_ch.valid && req_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the receiver in modes of random length
  int rx_mode;
  int rx_left = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(1, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
      default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Current settings, mirrored for address generation
  logic [47:0] cur_base;
  logic [4:0]  cur_shift;
  int unsigned cur_slots;
  int          burst_left;

  // Offer one request and hold it until accepted
  task automatic send_request(logic op, logic [39:0] pa, logic [47:0] va, logic dw);
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.phys_address <= pa;
    req_ch.virt_address <= va;
    req_ch.dont_wait    <= dw;
    do @(negedge clk_i); while (!req_fire);
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Write all three registers back to back
  task automatic write_settings(logic [47:0] base, logic [4:0] sh, logic [6:0] n);
    logic [47:0]        vals [3];
    rwm_pkg::cfg_idx_e  idx  [3];
    vals = '{base, {43'd0, sh}, {41'd0, n}};
    idx  = '{rwm_pkg::CFG_WINDOW_BASE, rwm_pkg::CFG_CHUNK_SHIFT, rwm_pkg::CFG_SLOT_COUNT};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(negedge clk_i); while (!cfg_fire);
    end
    cfg_ch.valid <= 1'b0;
    cur_base  = base;
    cur_shift = sh;
    cur_slots = n;
  endtask

  // Hold off the sender until every response has come back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [39:0] chunk_addr(int unsigned idx);
    return 40'((64'(idx) << cur_shift) | (64'({$urandom, $urandom}) &
               ((64'd1 << cur_shift) - 1)));
  endfunction

  function automatic logic [47:0] slot_addr(int unsigned slot);
    return 48'(64'(cur_base) + (64'(slot) << cur_shift) +
               (64'($urandom) & ((64'd1 << cur_shift) - 1)));
  endfunction

  task automatic random_request();
    logic [39:0] pa;
    logic [47:0] va;
    int unsigned pool;
    pa   = 40'({$urandom, $urandom});
    va   = 48'({$urandom, $urandom});
    pool = cur_slots + 4;
    if ($urandom_range(0, 99) < 58) begin
      if ($urandom_range(0, 19) == 0)
        pa = 40'({$urandom, $urandom});
      else if ($urandom_range(0, 9) == 0)
        pa = chunk_addr($urandom_range(0, rwm_pkg::PhysChunks - 1));
      else
        pa = chunk_addr($urandom_range(0, pool));
      send_request(1'b0, pa, va, 1'($urandom_range(0, 1)));
    end else begin
      if ($urandom_range(0, 19) != 0) va = slot_addr($urandom_range(0, cur_slots));
      send_request(1'b1, pa, va, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [47:0] bases  [Phases];
    logic [4:0]  shifts [Phases];
    logic [6:0]  counts [Phases];
    bases  = '{48'd0, 48'h1234_5600_0000, 48'hFFFF_FFF0_0000,
               48'({$urandom, $urandom}), 48'hFFFF_FFFF_FFFF, 48'd0};
    shifts = '{5'd12, 5'd24, 5'd16, 5'd12, 5'd20, 5'd12};
    counts = '{7'd64, 7'd1, 7'd4, 7'd2, 7'd64, 7'd8};

    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = 1'b0;
    req_ch.phys_address = '0;
    req_ch.virt_address = '0;
    req_ch.dont_wait    = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = rwm_pkg::CFG_WINDOW_BASE;
    cfg_ch.data         = '0;
    burst_left          = 5;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < Phases; p++) begin
      write_settings(bases[p], shifts[p], counts[p]);
      if (p == 0) begin
        // Field extremes, reuse, double release and out-of-window releases
        send_request(1'b0, 40'd0, 48'd0, 1'b0);
        send_request(1'b0, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_request(1'b0, 40'h3F_FFFF, 48'd0, 1'b0);
        send_request(1'b0, 40'h3F_F000, 48'd0, 1'b1);
        send_request(1'b0, 40'h40_0000, 48'd0, 1'b0);
        send_request(1'b1, 40'd0, 48'd0, 1'b0);
        send_request(1'b1, 40'd0, 48'h0FFF, 1'b0);
        send_request(1'b0, 40'h0123, 48'd0, 1'b0);
        send_request(1'b1, 40'd0, 48'h4_0000, 1'b0);
        send_request(1'b1, 40'd0, 48'h5000, 1'b0);
        send_request(1'b1, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
      end else if (p == 1) begin
        // Single slot: fail without waiting, block, wake, then evict
        send_request(1'b0, 40'h1_0000_0000, 48'd0, 1'b0);
        send_request(1'b0, 40'h2_0000_0000, 48'd0, 1'b1);
        send_request(1'b0, 40'h2_0000_0000, 48'd0, 1'b0);
        send_request(1'b1, 40'd0, 48'h1234_5600_0000, 1'b0);
        send_request(1'b0, 40'h2_00FF_FFFF, 48'd0, 1'b0);
        send_request(1'b0, 40'h1_0000_0000, 48'd0, 1'b1);
        send_request(1'b1, 40'd0, 48'h1234_56FF_FFFF, 1'b0);
        send_request(1'b1, 40'd0, 48'h1234_5700_0000, 1'b0);
        send_request(1'b1, 40'd0, 48'h1234_55FF_FFFF, 1'b0);
        send_request(1'b0, 40'h4_0000_0000, 48'd0, 1'b0);
      end
      for (int i = 0; i < ItemsPerPhase; i++) random_request();
      drain_responses();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/rwm_pkg.sv
hw/rtl/rwm_if.sv
hw/rtl/rwm_idle_cell.sv
hw/rtl/rwm_idle_queue.sv
hw/rtl/refcounted_window_mapper_lru_unit.sv
dv/rwm_mapper_checker.sv
dv/tb.sv
